// ===== src/dns_pkg.sv =====
// Shared constants, codes and types of the directional nearest-point selector.
// Used by dns_table, dns_mac, dns_score and directional_nearest_select.
package dns_pkg;

  localparam int DEPTH   = 64;
  localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int SUM_W   = 34;
  localparam int SCORE_W = 36;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // forward distance must exceed 0.001 in Q.18 units
  localparam logic signed [SUM_W-1:0] AHEAD_LIMIT = SUM_W'(262);

  typedef struct packed {
    logic signed [15:0] px;
    logic signed [15:0] py;
    logic [7:0]         grp;
    logic               inter;
  } entry_t;

  typedef struct packed {
    logic               valid;
    logic               xprod;
    logic               elig;
    logic [IDX_W-1:0]   idx;
    logic signed [16:0] a;
    logic signed [16:0] b;
    logic signed [15:0] c;
    logic signed [15:0] d;
  } mac_in_t;

  typedef struct packed {
    logic                    valid;
    logic                    xprod;
    logic                    elig;
    logic [IDX_W-1:0]        idx;
    logic signed [SUM_W-1:0] sum;
  } mac_out_t;

endpackage

// ===== src/directional_nearest_select.sv =====
// Directional nearest-point selector: sequencer around dns_table, dns_mac, dns_score.
// Write: result strobe in the cycle after start; busy stays low, one write per cycle.
// Query: result after the scan (and the wrap search, if enabled and nothing is found ahead),
// busy meanwhile; each slot takes two passes through the shared multiplier.
// Results cannot be stalled. Synchronous active-low reset clears valid marks, wrap_enable
// and control state; slots are invalid until written with in_keep_flag set.
module directional_nearest_select (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_opcode,
  input  logic [5:0]  in_slot_index,
  input  logic signed [15:0] in_pos_x,
  input  logic signed [15:0] in_pos_y,
  input  logic [7:0]  in_group_id,
  input  logic        in_interactable_flag,
  input  logic        in_keep_flag,
  input  logic signed [15:0] in_dir_x,
  input  logic signed [15:0] in_dir_y,
  output logic        out_valid,
  output logic        out_found,
  output logic [5:0]  out_target_index,
  output logic        out_wrapped,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_wrap_enable
);

  localparam int IdxW = dns_pkg::IDX_W;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_CUR   = 4'b0010,
    ST_SCAN  = 4'b0100,
    ST_DRAIN = 4'b1000
  } state_t;

  state_t                 state_r, state_nxt;
  logic [IdxW-1:0]        idx_r;
  logic                   phase_r;
  logic                   wrap_pass_r;
  logic [IdxW-1:0]        cur_idx_r;
  logic                   cur_ok_r;
  logic signed [15:0]     cur_px_r;
  logic signed [15:0]     cur_py_r;
  logic [7:0]             cur_grp_r;
  logic signed [15:0]     dxr_r;
  logic signed [15:0]     dyr_r;
  logic                   wrap_en_r;
  logic                   out_valid_r;
  logic                   out_found_r;
  logic [5:0]             out_target_r;
  logic                   out_wrapped_r;

  logic                   accept;
  logic                   in_range;
  logic                   tbl_wr_en;
  dns_pkg::entry_t        wr_entry;
  logic                   rd_en;
  logic [IdxW-1:0]        rd_idx;
  dns_pkg::entry_t        rd_entry;
  logic                   rd_valid;
  dns_pkg::mac_in_t       mac_op;
  dns_pkg::mac_out_t      mac_res;
  logic                   mac_pend;
  logic                   score_pend;
  logic                   have;
  logic [IdxW-1:0]        best_idx;
  logic                   last;
  logic                   elig;
  logic signed [16:0]     dx;
  logic signed [16:0]     dy;
  logic                   finish;
  logic                   fin_found;
  logic [5:0]             fin_target;
  logic                   fin_wrapped;
  logic                   start_wrap;
  logic                   cur_go;
  logic                   clear;

  assign busy      = (state_r != ST_IDLE);
  assign accept    = start && !busy;
  assign in_range  = ({26'd0, in_slot_index} < 32'(dns_pkg::DEPTH));
  assign cfg_ready = 1'b1;
  assign last      = (idx_r == IdxW'(dns_pkg::DEPTH - 1));
  assign clear     = accept && (in_opcode == dns_pkg::OP_QUERY);

  assign tbl_wr_en      = accept && (in_opcode == dns_pkg::OP_WRITE) && in_range;
  assign wr_entry.px    = in_pos_x;
  assign wr_entry.py    = in_pos_y;
  assign wr_entry.grp   = in_group_id;
  assign wr_entry.inter = in_interactable_flag;

  assign dx   = 17'($signed(rd_entry.px)) - 17'(cur_px_r);
  assign dy   = 17'($signed(rd_entry.py)) - 17'(cur_py_r);
  assign elig = rd_valid && rd_entry.inter && (rd_entry.grp == cur_grp_r) &&
                (idx_r != cur_idx_r);

  always_comb begin
    mac_op.valid = (state_r == ST_SCAN);
    mac_op.xprod = phase_r;
    mac_op.elig  = elig;
    mac_op.idx   = idx_r;
    if (phase_r) begin
      mac_op.a = dx;
      mac_op.b = dy;
      mac_op.c = dyr_r;
      mac_op.d = dxr_r;
    end else if (wrap_pass_r) begin
      mac_op.a = 17'($signed(rd_entry.px));
      mac_op.b = 17'($signed(rd_entry.py));
      mac_op.c = dxr_r;
      mac_op.d = dyr_r;
    end else begin
      mac_op.a = dx;
      mac_op.b = dy;
      mac_op.c = dxr_r;
      mac_op.d = dyr_r;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    rd_en       = 1'b0;
    rd_idx      = '0;
    finish      = 1'b0;
    fin_found   = 1'b0;
    fin_target  = '0;
    fin_wrapped = 1'b0;
    start_wrap  = 1'b0;
    cur_go      = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_opcode == dns_pkg::OP_QUERY) begin
            rd_en     = 1'b1;
            rd_idx    = IdxW'(in_slot_index);
            state_nxt = ST_CUR;
          end else begin
            finish = 1'b1;
          end
        end
      end
      ST_CUR: begin
        if (cur_ok_r && rd_valid) begin
          cur_go    = 1'b1;
          rd_en     = 1'b1;
          state_nxt = ST_SCAN;
        end else begin
          finish    = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      ST_SCAN: begin
        if (phase_r) begin
          if (last) begin
            state_nxt = ST_DRAIN;
          end else begin
            rd_en  = 1'b1;
            rd_idx = idx_r + 1'b1;
          end
        end
      end
      ST_DRAIN: begin
        if (!mac_pend && !score_pend) begin
          if (!wrap_pass_r && !have && wrap_en_r) begin
            start_wrap = 1'b1;
            rd_en      = 1'b1;
            state_nxt  = ST_SCAN;
          end else begin
            finish      = 1'b1;
            fin_found   = have;
            fin_target  = have ? 6'(best_idx) : 6'd0;
            fin_wrapped = have && wrap_pass_r;
            state_nxt   = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      wrap_en_r   <= 1'b0;
      out_valid_r <= 1'b0;
      phase_r     <= 1'b0;
      wrap_pass_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= finish;
      if (cfg_valid && cfg_ready) begin
        wrap_en_r <= cfg_wrap_enable;
      end
      if (clear) begin
        wrap_pass_r <= 1'b0;
      end else if (start_wrap) begin
        wrap_pass_r <= 1'b1;
      end
      if (cur_go || start_wrap) begin
        phase_r <= 1'b0;
      end else if (state_r == ST_SCAN) begin
        phase_r <= ~phase_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (clear) begin
      cur_idx_r <= IdxW'(in_slot_index);
      cur_ok_r  <= in_range;
      dxr_r     <= in_dir_x;
      dyr_r     <= in_dir_y;
    end
    if (cur_go) begin
      cur_px_r  <= rd_entry.px;
      cur_py_r  <= rd_entry.py;
      cur_grp_r <= rd_entry.grp;
    end
    if (cur_go || start_wrap) begin
      idx_r <= '0;
    end else if ((state_r == ST_SCAN) && phase_r && !last) begin
      idx_r <= idx_r + 1'b1;
    end
    if (finish) begin
      out_found_r   <= fin_found;
      out_target_r  <= fin_target;
      out_wrapped_r <= fin_wrapped;
    end
  end

  dns_table u_table (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (tbl_wr_en),
    .wr_keep  (in_keep_flag),
    .wr_idx   (IdxW'(in_slot_index)),
    .wr_entry (wr_entry),
    .rd_en    (rd_en),
    .rd_idx   (rd_idx),
    .rd_entry (rd_entry),
    .rd_valid (rd_valid)
  );

  dns_mac u_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .op    (mac_op),
    .res   (mac_res),
    .pend  (mac_pend)
  );

  dns_score u_score (
    .clk       (clk),
    .rst_n     (rst_n),
    .clear     (clear),
    .wrap_pass (wrap_pass_r),
    .res       (mac_res),
    .have      (have),
    .best_idx  (best_idx),
    .pend      (score_pend)
  );

  assign out_valid        = out_valid_r;
  assign out_found        = out_found_r;
  assign out_target_index = out_target_r;
  assign out_wrapped      = out_wrapped_r;

endmodule

// ===== src/dns_table.sv =====
// Point table: entry memory with one registered read port plus per-slot valid flops.
// Depends on dns_pkg.
module dns_table (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      wr_en,
  input  logic                      wr_keep,
  input  logic [dns_pkg::IDX_W-1:0] wr_idx,
  input  dns_pkg::entry_t           wr_entry,
  input  logic                      rd_en,
  input  logic [dns_pkg::IDX_W-1:0] rd_idx,
  output dns_pkg::entry_t           rd_entry,
  output logic                      rd_valid
);

  dns_pkg::entry_t            mem_r [dns_pkg::DEPTH];
  logic [dns_pkg::DEPTH-1:0]  valid_r;
  dns_pkg::entry_t            rd_entry_r;
  logic                       rd_valid_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_idx] <= wr_keep ? wr_entry : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (wr_en) begin
      valid_r[wr_idx] <= wr_keep;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_entry_r <= mem_r[rd_idx];
      rd_valid_r <= valid_r[rd_idx];
    end
  end

  assign rd_entry = rd_entry_r;
  assign rd_valid = rd_valid_r;

endmodule

// ===== src/dns_mac.sv =====
// Shared two-stage multiply unit: a*c + b*d, or a*c - b*d for cross products.
// Depends on dns_pkg.
module dns_mac (
  input  logic              clk,
  input  logic              rst_n,
  input  dns_pkg::mac_in_t  op,
  output dns_pkg::mac_out_t res,
  output logic              pend
);

  logic                             s1_valid_r;
  logic                             s1_cross_r;
  logic                             s1_elig_r;
  logic [dns_pkg::IDX_W-1:0]        s1_idx_r;
  logic signed [32:0]               p0_r;
  logic signed [32:0]               p1_r;
  logic                             s2_valid_r;
  logic                             s2_cross_r;
  logic                             s2_elig_r;
  logic [dns_pkg::IDX_W-1:0]        s2_idx_r;
  logic signed [dns_pkg::SUM_W-1:0] sum_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= op.valid;
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_cross_r <= op.xprod;
    s1_elig_r  <= op.elig;
    s1_idx_r   <= op.idx;
    p0_r       <= 33'($signed(op.a)) * 33'($signed(op.c));
    p1_r       <= 33'($signed(op.b)) * 33'($signed(op.d));
    s2_cross_r <= s1_cross_r;
    s2_elig_r  <= s1_elig_r;
    s2_idx_r   <= s1_idx_r;
    if (s1_cross_r) begin
      sum_r <= dns_pkg::SUM_W'(p0_r) - dns_pkg::SUM_W'(p1_r);
    end else begin
      sum_r <= dns_pkg::SUM_W'(p0_r) + dns_pkg::SUM_W'(p1_r);
    end
  end

  assign res.valid = s2_valid_r;
  assign res.xprod = s2_cross_r;
  assign res.elig  = s2_elig_r;
  assign res.idx   = s2_idx_r;
  assign res.sum   = sum_r;
  assign pend      = s1_valid_r | s2_valid_r;

endmodule

// ===== src/dns_score.sv =====
// Scoring and best-candidate tracking for the ahead and wrap scans.
// Depends on dns_pkg; fed by dns_mac.
module dns_score (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      clear,
  input  logic                      wrap_pass,
  input  dns_pkg::mac_out_t         res,
  output logic                      have,
  output logic [dns_pkg::IDX_W-1:0] best_idx,
  output logic                      pend
);

  logic signed [dns_pkg::SUM_W-1:0]   sum_s;
  logic signed [dns_pkg::SUM_W-1:0]   side;
  logic signed [dns_pkg::SUM_W-1:0]   fwd_r;
  logic signed [dns_pkg::SCORE_W-1:0] score_nxt;
  logic                               ok_nxt;
  logic signed [dns_pkg::SCORE_W-1:0] score_r;
  logic [dns_pkg::IDX_W-1:0]          score_idx_r;
  logic                               score_ok_r;
  logic                               score_valid_r;
  logic signed [dns_pkg::SCORE_W-1:0] best_r;
  logic [dns_pkg::IDX_W-1:0]          best_idx_r;
  logic                               have_r;
  logic                               take;

  assign sum_s = res.sum;

  always_comb begin
    side = (sum_s < 0) ? -sum_s : sum_s;
    if (wrap_pass) begin
      score_nxt = (dns_pkg::SCORE_W'(fwd_r) <<< 2) + dns_pkg::SCORE_W'(side);
      ok_nxt    = res.elig;
    end else begin
      score_nxt = dns_pkg::SCORE_W'(fwd_r) + (dns_pkg::SCORE_W'(side) <<< 1);
      ok_nxt    = res.elig && (fwd_r > dns_pkg::AHEAD_LIMIT);
    end
  end

  assign take = score_valid_r && score_ok_r && (!have_r || (score_r < best_r));

  always_ff @(posedge clk) begin
    if (res.valid && !res.xprod) begin
      fwd_r <= sum_s;
    end
    score_r     <= score_nxt;
    score_idx_r <= res.idx;
    score_ok_r  <= ok_nxt;
    if (take) begin
      best_r     <= score_r;
      best_idx_r <= score_idx_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      score_valid_r <= 1'b0;
      have_r        <= 1'b0;
    end else begin
      score_valid_r <= res.valid && res.xprod;
      if (clear) begin
        have_r <= 1'b0;
      end else if (take) begin
        have_r <= 1'b1;
      end
    end
  end

  assign have     = have_r;
  assign best_idx = best_idx_r;
  assign pend     = score_valid_r;

endmodule
